>>> rtl/core/ibt_pkg.sv
// shared types and constants of the interval booking table
package ibt_pkg;

   localparam int STAMP_W = 32;
   localparam int SLOT_W  = 6;

   // request command codes
   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_DELETE = 1'b1
   } ibt_cmd_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_CONFLICT  = 3'd1,
      ST_FULL      = 3'd2,
      ST_DELETED   = 3'd3,
      ST_NOT_FOUND = 3'd4
   } ibt_status_type;

   // one request transfer
   typedef struct packed {
      ibt_cmd_type               command;
      logic signed [STAMP_W-1:0] start_time;
      logic signed [STAMP_W-1:0] end_time;
      logic signed [STAMP_W-1:0] remind_stamp;
   } ibt_req_type;

   // one result transfer
   typedef struct packed {
      ibt_status_type    status;
      logic [SLOT_W-1:0] slot_index;
   } ibt_rsp_type;

   // one table entry as held in the ram
   typedef struct packed {
      logic                      valid;
      logic signed [STAMP_W-1:0] start_time;
      logic signed [STAMP_W-1:0] end_time;
      logic signed [STAMP_W-1:0] remind_stamp;
   } ibt_entry_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic clear_step;
      logic scan_step;
      logic finish;
   } ibt_ctl_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic hit;
      logic scan_last;
      logic clear_last;
   } ibt_stat_type;

endpackage

>>> rtl/core/ibt_ram.sv
// generic simple dual port ram with registered read
module ibt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ibt_dpath.sv
// datapath: request latch, scan counters, overlap compare and table ram
module ibt_dpath #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ibt_pkg::ibt_ctl_type ctl,
   output ibt_pkg::ibt_stat_type stat,
   input  ibt_pkg::ibt_req_type req_data,
   output logic                 rsp_valid,
   output ibt_pkg::ibt_rsp_type rsp_data
);

   localparam int AW    = $clog2(TABLE_ENTRIES);
   localparam int SlotW = ibt_pkg::SLOT_W;
   localparam int EW    = $bits(ibt_pkg::ibt_entry_type);
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

   ibt_pkg::ibt_req_type  req_ff;
   logic [AW-1:0]         addr_ff, addr_in;
   logic [AW-1:0]         eval_ff, eval_in;
   logic                  eval_vld_ff, eval_vld_in;
   logic                  have_free_ff, have_free_in;
   logic [AW-1:0]         free_ff, free_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ibt_pkg::ibt_rsp_type  rsp_ff, rsp_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   ibt_pkg::ibt_entry_type wr_entry;
   logic [EW-1:0]         rd_word;
   ibt_pkg::ibt_entry_type rd_entry;

   logic                  overlap;
   logic                  conflict;
   logic                  del_match;
   logic                  hit;
   logic                  last;
   logic                  free_now;
   logic [AW-1:0]         free_idx;

   assign rd_entry = ibt_pkg::ibt_entry_type'(rd_word);

   // compare the entry read back against the latched request
   always_comb begin
      overlap   = (rd_entry.start_time < req_ff.end_time) &&
                  (req_ff.start_time < rd_entry.end_time);
      conflict  = rd_entry.valid &&
                  (overlap || (rd_entry.start_time == req_ff.start_time));
      del_match = rd_entry.valid && (rd_entry.start_time == req_ff.start_time);
      hit       = eval_vld_ff &&
                  ((req_ff.command == ibt_pkg::CMD_INSERT) ? conflict : del_match);
      last      = eval_vld_ff && (eval_ff == LAST_ADDR);
      free_now  = have_free_ff || !rd_entry.valid;
      free_idx  = have_free_ff ? free_ff : eval_ff;
   end

   assign stat.hit        = hit;
   assign stat.scan_last  = last;
   assign stat.clear_last = (addr_ff == LAST_ADDR);

   // counters, free slot tracking, result and ram write
   always_comb begin
      addr_in      = addr_ff;
      eval_in      = eval_ff;
      eval_vld_in  = eval_vld_ff;
      have_free_in = have_free_ff;
      free_in      = free_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_entry     = '0;

      if (ctl.clear_step) begin
         // clearing pass writes an empty entry each cycle
         wr_en = 1'b1;
         if (addr_ff != LAST_ADDR) begin
            addr_in = addr_ff + 1'b1;
         end else begin
            addr_in = '0;
         end
      end

      if (ctl.load) begin
         addr_in      = '0;
         eval_vld_in  = 1'b0;
         have_free_in = 1'b0;
      end

      if (ctl.scan_step) begin
         eval_in     = addr_ff;
         eval_vld_in = 1'b1;
         if (addr_ff != LAST_ADDR) begin
            addr_in = addr_ff + 1'b1;
         end
         // remember the lowest free slot seen so far
         if (eval_vld_ff && !rd_entry.valid && !have_free_ff) begin
            have_free_in = 1'b1;
            free_in      = eval_ff;
         end
      end

      if (ctl.finish) begin
         rsp_valid_in = 1'b1;
         if (req_ff.command == ibt_pkg::CMD_INSERT) begin
            if (hit) begin
               rsp_in.status     = ibt_pkg::ST_CONFLICT;
               rsp_in.slot_index = SlotW'(eval_ff);
            end else if (free_now) begin
               rsp_in.status          = ibt_pkg::ST_INSERTED;
               rsp_in.slot_index      = SlotW'(free_idx);
               wr_en                  = 1'b1;
               wr_addr                = free_idx;
               wr_entry.valid         = 1'b1;
               wr_entry.start_time    = req_ff.start_time;
               wr_entry.end_time      = req_ff.end_time;
               wr_entry.remind_stamp  = req_ff.remind_stamp;
            end else begin
               rsp_in.status     = ibt_pkg::ST_FULL;
               rsp_in.slot_index = '0;
            end
         end else begin
            if (hit) begin
               rsp_in.status     = ibt_pkg::ST_DELETED;
               rsp_in.slot_index = SlotW'(eval_ff);
               wr_en             = 1'b1;
               wr_addr           = eval_ff;
            end else begin
               rsp_in.status     = ibt_pkg::ST_NOT_FOUND;
               rsp_in.slot_index = '0;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         eval_vld_ff  <= 1'b0;
         have_free_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         addr_ff      <= addr_in;
         eval_vld_ff  <= eval_vld_in;
         have_free_ff <= have_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req_data;
      end
      eval_ff <= eval_in;
      free_ff <= free_in;
      rsp_ff  <= rsp_in;
   end

   ibt_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (addr_ff),
      .rd_data (rd_word)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/core/ibt_ctrl.sv
// controller: clearing pass, request acceptance and table scan sequencing
module ibt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output ibt_pkg::ibt_ctl_type  ctl,
   input  ibt_pkg::ibt_stat_type stat
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            ctl.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            ctl.scan_step = 1'b1;
            if (stat.hit || stat.scan_last) begin
               ctl.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      busy_in = (state_in != S_IDLE);
   end

   // state and registered busy
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

>>> rtl/core/interval_booking_table_top.sv
// top level of the interval booking table
//
// Keeps up to TABLE_ENTRIES booked intervals (start, exclusive end, reminder).
// Request channel: a transfer happens at a rising edge with start high and
// busy low; req_data carries command, start_time, end_time, remind_stamp.
// Insert books the interval in the lowest free slot unless it overlaps a
// stored one or shares its start; delete frees the entry with that start.
// Result channel: rsp_valid is high for exactly one cycle per request, with
// status and slot_index on rsp_data; the receiver cannot stall it.
// Scan: the table ram is scanned one entry a cycle through its read port
// and the scan stops at the first hit or at the last entry; the result is
// then registered onto rsp_data with the strobe, and busy drops with the
// strobe. A new request may be given in the cycle in which the previous
// result is shown.
// Reset: a clearing pass writes every entry empty, with busy held high
// until it is done.
module interval_booking_table_top #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ibt_pkg::ibt_req_type req_data,
   output logic                 rsp_valid,
   output ibt_pkg::ibt_rsp_type rsp_data
);

   ibt_pkg::ibt_ctl_type  ctl;
   ibt_pkg::ibt_stat_type stat;

   ibt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctl   (ctl),
      .stat  (stat)
   );

   ibt_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // an accepted request keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request transfer");

   // each result strobe lasts a single cycle
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // a result only follows a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a request in progress");

   // reported status is a defined code
   a_rsp_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status <= ibt_pkg::ST_NOT_FOUND))
      else $error("undefined result status");
`endif

endmodule

>>> tb/interval_booking_table_top_tb.sv
// self-checking testbench of the interval booking table top level
`timescale 1ns / 100ps

module interval_booking_table_top_tb;

   localparam int TABLE_ENTRIES = 64;
   localparam int STAMP_W       = ibt_pkg::STAMP_W;
   localparam int SLOT_W        = ibt_pkg::SLOT_W;
   // booking grid used by the random part: disjoint cells, more cells than slots
   localparam int GRID_STEP     = 1 << 16;
   localparam int GRID_CELLS    = 96;
   // cycles with no transfer before the run is declared hung
   localparam int STALL_LIMIT   = 4000;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   ibt_pkg::ibt_req_type req_data;
   logic                 rsp_valid;
   ibt_pkg::ibt_rsp_type rsp_data;

   // predicted table contents
   bit                        bk_valid [TABLE_ENTRIES];
   logic signed [STAMP_W-1:0] bk_start [TABLE_ENTRIES];
   logic signed [STAMP_W-1:0] bk_end   [TABLE_ENTRIES];
   logic signed [STAMP_W-1:0] bk_remind[TABLE_ENTRIES];

   ibt_pkg::ibt_rsp_type pending_outcomes[$];
   int          send_idle_pct;
   int          grid_origin;
   int          error_count;
   int          request_count;
   int          outcome_count;
   int          status_seen[5];
   int          stall_cycles;

   interval_booking_table_top #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // work out the outcome of one request and update the predicted table
   function automatic ibt_pkg::ibt_rsp_type book_or_cancel(input ibt_pkg::ibt_req_type r);
      ibt_pkg::ibt_rsp_type      res;
      logic signed [STAMP_W-1:0] ns;
      logic signed [STAMP_W-1:0] ne;
      bit                        have_free;
      int                        free_slot;
      res.status     = ibt_pkg::ST_NOT_FOUND;
      res.slot_index = '0;
      ns             = r.start_time;
      ne             = r.end_time;
      have_free      = 1'b0;
      free_slot      = 0;
      if (r.command == ibt_pkg::CMD_INSERT) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (bk_valid[i]) begin
               // half-open overlap, or the same start stamp
               if ((bk_start[i] < ne && ns < bk_end[i]) || bk_start[i] == ns) begin
                  res.status     = ibt_pkg::ST_CONFLICT;
                  res.slot_index = SLOT_W'(i);
                  return res;
               end
            end else if (!have_free) begin
               have_free = 1'b1;
               free_slot = i;
            end
         end
         if (!have_free) begin
            res.status = ibt_pkg::ST_FULL;
            return res;
         end
         bk_valid[free_slot]  = 1'b1;
         bk_start[free_slot]  = ns;
         bk_end[free_slot]    = ne;
         bk_remind[free_slot] = r.remind_stamp;
         res.status           = ibt_pkg::ST_INSERTED;
         res.slot_index       = SLOT_W'(free_slot);
         return res;
      end
      // delete by start stamp, lowest match
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (bk_valid[i] && bk_start[i] == ns) begin
            bk_valid[i]    = 1'b0;
            res.status     = ibt_pkg::ST_DELETED;
            res.slot_index = SLOT_W'(i);
            return res;
         end
      end
      return res;
   endfunction

   function automatic ibt_pkg::ibt_req_type make_req(input ibt_pkg::ibt_cmd_type cmd,
                                                     input int s, input int e,
                                                     input int rm);
      ibt_pkg::ibt_req_type r;
      r.command      = cmd;
      r.start_time   = s;
      r.end_time     = e;
      r.remind_stamp = rm;
      return r;
   endfunction

   // random booked slot, or -1 when the table is empty
   function automatic int pick_booked_slot();
      int taken[$];
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (bk_valid[i]) taken.push_back(i);
      if (taken.size() == 0) return -1;
      return taken[$urandom_range(taken.size() - 1)];
   endfunction

   // one random request: grid bookings, cancels of booked starts, and noise
   function automatic ibt_pkg::ibt_req_type make_booking_request(input int insert_pct);
      ibt_pkg::ibt_req_type r;
      int          pick;
      int          slot;
      int          len;
      r    = make_req(ibt_pkg::CMD_INSERT, $urandom, $urandom, $urandom);
      pick = $urandom_range(99);
      if (pick < 10) begin
         // noise with every field random
         r.command = ibt_pkg::ibt_cmd_type'($urandom_range(1));
      end else if (pick < 10 + insert_pct * 90 / 100) begin
         slot         = $urandom_range(GRID_CELLS - 1);
         r.start_time = grid_origin + slot * GRID_STEP;
         case ($urandom_range(7))
            0: begin
               // empty or inverted interval
               len = -$urandom_range(GRID_STEP);
            end
            1: begin
               // may run into the next cell
               len = $urandom_range(2 * GRID_STEP, 1);
            end
            default: begin
               len = $urandom_range(GRID_STEP, 1);
            end
         endcase
         r.end_time = r.start_time + len;
      end else begin
         r.command = ibt_pkg::CMD_DELETE;
         slot      = pick_booked_slot();
         if (slot >= 0 && $urandom_range(3) != 0)
            r.start_time = bk_start[slot];
         else
            r.start_time = grid_origin + $urandom_range(GRID_CELLS - 1) * GRID_STEP;
      end
      return r;
   endfunction

   // new grid origin that keeps the whole grid clear of wrap-around
   task automatic move_grid();
      grid_origin = int'($urandom_range(32'hFE00_0000) + 32'h8000_0000);
   endtask

   // offer one request and wait for its transfer
   task automatic send_request(input ibt_pkg::ibt_req_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_outcomes.push_back(book_or_cancel(r));
      request_count++;
   endtask

   // sender holds off until every outstanding result is back
   task automatic test_drain_pause();
      @(negedge clock);
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // field extremes, half-open edges, equal starts, inverted intervals, misses
   task automatic test_directed_cases();
      localparam int S_MIN = 32'sh8000_0000;
      localparam int S_MAX = 32'sh7FFF_FFFF;
      send_request(make_req(ibt_pkg::CMD_DELETE, 0, $urandom, $urandom));
      send_request(make_req(ibt_pkg::CMD_INSERT, S_MIN, S_MIN + 10, S_MAX));
      send_request(make_req(ibt_pkg::CMD_INSERT, S_MAX - 10, S_MAX, S_MIN));
      send_request(make_req(ibt_pkg::CMD_INSERT, S_MIN, S_MIN, 0));
      send_request(make_req(ibt_pkg::CMD_INSERT, S_MIN + 5, S_MAX, -1));
      send_request(make_req(ibt_pkg::CMD_INSERT, 100, 100, 7));
      send_request(make_req(ibt_pkg::CMD_INSERT, 200, 50, 8));
      send_request(make_req(ibt_pkg::CMD_INSERT, S_MIN + 10, S_MIN + 20, 9));
      send_request(make_req(ibt_pkg::CMD_INSERT, S_MIN + 19, S_MIN + 30, 10));
      send_request(make_req(ibt_pkg::CMD_INSERT, S_MAX - 20, S_MAX - 10, 11));
      send_request(make_req(ibt_pkg::CMD_INSERT, S_MAX - 20, S_MAX - 15, 12));
      send_request(make_req(ibt_pkg::CMD_DELETE, 100, S_MAX, S_MIN));
      send_request(make_req(ibt_pkg::CMD_INSERT, 1000, 2000, S_MAX));
      send_request(make_req(ibt_pkg::CMD_INSERT, 1999, 2000, 0));
      send_request(make_req(ibt_pkg::CMD_INSERT, 1500, 1600, 0));
      send_request(make_req(ibt_pkg::CMD_INSERT, 2000, 3000, 0));
      send_request(make_req(ibt_pkg::CMD_DELETE, 12345, 0, 0));
      send_request(make_req(ibt_pkg::CMD_DELETE, S_MAX, -1, -1));
      send_request(make_req(ibt_pkg::CMD_DELETE, S_MIN, 0, 0));
      send_request(make_req(ibt_pkg::CMD_DELETE, S_MIN, 0, 0));
      send_request(make_req(ibt_pkg::CMD_INSERT, -1, 0, -1));
      send_request(make_req(ibt_pkg::CMD_INSERT, 0, -1, 0));
   endtask

   // empty the table, fill every slot, then refuse, conflict and refill
   task automatic test_table_full();
      int slot;
      int s;
      move_grid();
      slot = pick_booked_slot();
      while (slot >= 0) begin
         send_request(make_req(ibt_pkg::CMD_DELETE, bk_start[slot], $urandom, $urandom));
         slot = pick_booked_slot();
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         s = grid_origin + i * GRID_STEP;
         send_request(make_req(ibt_pkg::CMD_INSERT, s, s + $urandom_range(GRID_STEP, 1),
                               $urandom));
      end
      // fresh interval into a full table
      s = grid_origin + (TABLE_ENTRIES + 3) * GRID_STEP;
      send_request(make_req(ibt_pkg::CMD_INSERT, s, s + 1, $urandom));
      // conflict takes priority over full
      s = grid_origin + 3 * GRID_STEP;
      send_request(make_req(ibt_pkg::CMD_INSERT, s, s + 1, $urandom));
      s = grid_origin + 40 * GRID_STEP;
      send_request(make_req(ibt_pkg::CMD_DELETE, s, $urandom, $urandom));
      s = grid_origin + (TABLE_ENTRIES + 3) * GRID_STEP;
      send_request(make_req(ibt_pkg::CMD_INSERT, s, s + 1, $urandom));
   endtask

   // random traffic, alternating fill-heavy and cancel-heavy stretches
   task automatic test_random_mix(input int n_items, input int idle_pct);
      int insert_pct;
      send_idle_pct = idle_pct;
      insert_pct    = 85;
      move_grid();
      for (int n = 0; n < n_items; n++) begin
         if (n % 40 == 39) insert_pct = (insert_pct == 85) ? 35 : 85;
         if (n % 150 == 149) move_grid();
         send_request(make_booking_request(insert_pct));
      end
   endtask

   // compare each result with the oldest prediction
   always @(posedge clock) begin : result_check
      ibt_pkg::ibt_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result, expected none, got status %0d slot %0d",
                     $time, rsp_data.status, rsp_data.slot_index);
            error_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, got %0d",
                        $time, want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.slot_index !== want.slot_index) begin
               $display("%0t: slot_index mismatch, expected %0d, got %0d",
                        $time, want.slot_index, rsp_data.slot_index);
               error_count++;
            end
            if (want.status <= ibt_pkg::ST_NOT_FOUND) status_seen[want.status]++;
            outcome_count++;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("FAIL interval_booking_table_top");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_data      = '0;
      send_idle_pct = 0;
      grid_origin   = 0;
      error_count   = 0;
      request_count = 0;
      outcome_count = 0;
      stall_cycles  = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      foreach (bk_valid[i]) bk_valid[i] = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 14;
      test_directed_cases();
      test_table_full();
      test_drain_pause();
      test_random_mix(390, 14);
      test_drain_pause();
      test_random_mix(390, 65);
      test_drain_pause();
      test_random_mix(390, 0);

      // let the last results come back, then watch for strays
      test_drain_pause();
      repeat (TABLE_ENTRIES + 8) @(posedge clock);

      $display("run covered %0d requests, %0d results checked", request_count, outcome_count);
      $display("outcomes: inserted %0d, conflict %0d, full %0d, deleted %0d, not found %0d",
               status_seen[ibt_pkg::ST_INSERTED], status_seen[ibt_pkg::ST_CONFLICT],
               status_seen[ibt_pkg::ST_FULL], status_seen[ibt_pkg::ST_DELETED],
               status_seen[ibt_pkg::ST_NOT_FOUND]);
      if (error_count == 0 && pending_outcomes.size() == 0) begin
         $display("PASS interval_booking_table_top");
      end else begin
         $display("FAIL interval_booking_table_top");
      end
      $finish;
   end

endmodule
